// ----- design/tbq_pkg.sv -----
// Shared types and constants for the token bucket shaped line queue.
// Used by the channel interfaces, the cell chain, the bucket and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tbq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int HANDLE_W = 32;
    localparam int KIND_W   = 2;
    localparam int FILL_W   = 5;
    localparam int TOK_W    = 17;
    localparam int RATE_W   = 16;
    localparam int WAIT_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register reset values (Q8.8 for token quantities)
    localparam logic [RATE_W-1:0] BURST_RESET_VAL  = 16'd1280;
    localparam logic [RATE_W-1:0] FILL_RESET_VAL   = 16'd128;
    localparam logic [RATE_W-1:0] COST_RESET_VAL   = 16'd256;
    localparam logic [WAIT_W-1:0] QUEUE_WAIT_TICKS = 24'd2;

    // Request codes
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_ENQUEUE = 1'b1;

    // Event codes
    localparam logic [KIND_W-1:0] EV_ACCEPTED = 2'd0;
    localparam logic [KIND_W-1:0] EV_DROPPED  = 2'd1;
    localparam logic [KIND_W-1:0] EV_SENT     = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BURST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT  = 3'd3;

    // Per-cell control from the queue controller
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    // Per-item request to the bucket
    typedef struct packed {
        logic fire;
        logic is_tick;
        logic has_line;
    } bkt_step_t;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0]   event_kind;
        logic [HANDLE_W-1:0] sent_handle;
        logic [FILL_W-1:0]   fill_level;
        logic                last_of_step;
    } result_t;

endpackage

`default_nettype wire

// ----- design/tbq_chan_if.sv -----
// Valid/ready channel interfaces for request and result items.
// Depends on tbq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tbq_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [tbq_pkg::HANDLE_W-1:0]  line_handle;

    modport source (output valid, output req_type, output line_handle, input ready);
    modport sink   (input valid, input req_type, input line_handle, output ready);
endinterface

interface tbq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tbq_pkg::KIND_W-1:0]    event_kind;
    logic [tbq_pkg::HANDLE_W-1:0]  sent_handle;
    logic [tbq_pkg::FILL_W-1:0]    fill_level;
    logic                          last_of_step;

    modport source (output valid, output event_kind, output sent_handle,
                    output fill_level, output last_of_step, input ready);
    modport sink   (input valid, input event_kind, input sent_handle,
                    input fill_level, input last_of_step, output ready);
endinterface

`default_nettype wire

// ----- design/tbq_cell.sv -----
// One storage cell of the line queue chain: holds a handle, shifts from its neighbor.
// Depends on tbq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbq_cell (
    input  wire logic                          clk,
    input  wire tbq_pkg::cell_ctrl_t           ctrl,
    input  wire logic [tbq_pkg::HANDLE_W-1:0]  new_data,
    input  wire logic [tbq_pkg::HANDLE_W-1:0]  next_data,
    output      logic [tbq_pkg::HANDLE_W-1:0]  data
);

    logic [tbq_pkg::HANDLE_W-1:0] data_reg;
    logic [tbq_pkg::HANDLE_W-1:0] data_next;

    // Load a new handle, else advance from the neighbor on pop, else hold
    always_comb
    begin
        if (ctrl.load)
        begin
            data_next = new_data;
        end
        else if (ctrl.shift)
        begin
            data_next = next_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ----- design/tbq_bucket.sv -----
// Token bucket and sender state: config registers, token level, arm and wait logic.
// Depends on tbq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbq_bucket (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [tbq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tbq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire tbq_pkg::bkt_step_t              step,
    output      logic                            pop
);

    localparam int SUM_W = tbq_pkg::TOK_W + 1;

    logic [tbq_pkg::RATE_W-1:0] burst_reg;
    logic [tbq_pkg::RATE_W-1:0] fill_reg;
    logic [tbq_pkg::RATE_W-1:0] cost_reg;
    logic [tbq_pkg::WAIT_W-1:0] wait_cfg_reg;

    logic signed [tbq_pkg::TOK_W-1:0] tok_reg;
    logic signed [tbq_pkg::TOK_W-1:0] tok_next;
    logic                             armed_reg;
    logic                             armed_next;
    logic                             waiting_reg;
    logic                             waiting_next;
    logic [tbq_pkg::WAIT_W-1:0]       wait_rem_reg;
    logic [tbq_pkg::WAIT_W-1:0]       wait_rem_next;

    logic signed [SUM_W-1:0] tok_ext;
    logic signed [SUM_W-1:0] burst_ext;
    logic signed [SUM_W-1:0] cost_ext;
    logic signed [SUM_W-1:0] refill_sum;
    logic signed [SUM_W-1:0] tok_a;
    logic signed [SUM_W-1:0] tok_sub;
    logic [tbq_pkg::WAIT_W-1:0] rem_dec;
    logic overdraw;
    logic armed_b;
    logic waiting_b;
    logic try_arm;
    logic cost_ok;
    logic wait_zero;
    logic take_cost;
    logic armed_c;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_reg    <= tbq_pkg::BURST_RESET_VAL;
            fill_reg     <= tbq_pkg::FILL_RESET_VAL;
            cost_reg     <= tbq_pkg::COST_RESET_VAL;
            wait_cfg_reg <= tbq_pkg::QUEUE_WAIT_TICKS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tbq_pkg::CFG_BURST: burst_reg    <= cfg_data[tbq_pkg::RATE_W-1:0];
                tbq_pkg::CFG_FILL:  fill_reg     <= cfg_data[tbq_pkg::RATE_W-1:0];
                tbq_pkg::CFG_COST:  cost_reg     <= cfg_data[tbq_pkg::RATE_W-1:0];
                tbq_pkg::CFG_WAIT:  wait_cfg_reg <= cfg_data[tbq_pkg::WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Refill on tick, count down the wait, then attempt to arm
    always_comb
    begin
        tok_ext    = SUM_W'(tok_reg);
        burst_ext  = $signed({2'b00, burst_reg});
        cost_ext   = $signed({2'b00, cost_reg});
        refill_sum = tok_ext + $signed({2'b00, fill_reg});

        tok_a = tok_ext;
        if (step.is_tick && (tok_ext < burst_ext))
        begin
            tok_a = (refill_sum > burst_ext) ? burst_ext : refill_sum;
        end

        rem_dec   = (wait_rem_reg != '0) ? (wait_rem_reg - 1'b1) : wait_rem_reg;
        overdraw  = step.is_tick && waiting_reg && (rem_dec == '0);
        armed_b   = armed_reg | overdraw;
        waiting_b = waiting_reg & ~overdraw;

        try_arm   = !armed_b && !waiting_b;
        cost_ok   = cost_ext <= tok_a;
        wait_zero = (wait_cfg_reg == '0);
        take_cost = overdraw | (try_arm & (cost_ok | wait_zero));
        tok_sub   = tok_a - cost_ext;

        tok_next = (take_cost ? tok_sub[tbq_pkg::TOK_W-1:0] : tok_a[tbq_pkg::TOK_W-1:0]);
        armed_c  = armed_b | (try_arm & (cost_ok | wait_zero));
        pop      = armed_c & step.has_line;

        armed_next   = armed_c & ~pop;
        waiting_next = waiting_b | (try_arm & ~cost_ok & ~wait_zero);
        if (overdraw)
        begin
            wait_rem_next = '0;
        end
        else if (try_arm & ~cost_ok & ~wait_zero)
        begin
            wait_rem_next = wait_cfg_reg;
        end
        else if (step.is_tick && waiting_reg)
        begin
            wait_rem_next = rem_dec;
        end
        else
        begin
            wait_rem_next = wait_rem_reg;
        end
    end

    // Commit bucket state for each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg      <= $signed({1'b0, tbq_pkg::BURST_RESET_VAL});
            armed_reg    <= 1'b0;
            waiting_reg  <= 1'b0;
            wait_rem_reg <= '0;
        end
        else if (step.fire)
        begin
            tok_reg      <= tok_next;
            armed_reg    <= armed_next;
            waiting_reg  <= waiting_next;
            wait_rem_reg <= wait_rem_next;
        end
    end

    a_armed_excl_wait: assert property (@(posedge clk) disable iff (!rst_n)
        !(armed_reg && waiting_reg))
        else $error("sender armed and waiting at once");

    a_wait_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        waiting_reg |-> (wait_rem_reg != '0))
        else $error("sender waiting with no ticks left");

    a_pop_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (step.fire && pop) |=> !armed_reg)
        else $error("sender still armed after sending a line");

endmodule

`default_nettype wire

// ----- design/token_bucket_shaped_line_queue_top.sv -----
// Top level: shifting cell chain line queue paced by a token bucket, with result buffer.
// Depends on tbq_pkg, tbq_chan_if, tbq_cell and tbq_bucket.
// The first result of an item is valid in the cycle after the item is accepted.
// Throughput: one item per cycle if it gives at most one result and results are taken;
//   two results stall the next item; the two-entry buffer drains one result per cycle.
// Reset: queue empty, token level at the burst reset value, sender idle; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module token_bucket_shaped_line_queue_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    tbq_req_if.sink                              req,
    tbq_rsp_if.source                            rsp,
    input  wire logic                            cfg_we,
    input  wire logic [tbq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tbq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH = tbq_pkg::QUEUE_DEPTH;
    localparam int CNT_W = tbq_pkg::CNT_W;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_push;
    logic [CNT_W-1:0] load_pos;
    logic             fire;
    logic             is_enq;
    logic             full;
    logic             push;
    logic             pop;
    logic [tbq_pkg::HANDLE_W-1:0] head;
    tbq_pkg::bkt_step_t step;

    logic [tbq_pkg::HANDLE_W-1:0] cell_data [DEPTH];
    tbq_pkg::cell_ctrl_t          cell_ctrl [DEPTH];

    tbq_pkg::result_t slot_a_reg;
    tbq_pkg::result_t slot_a_next;
    tbq_pkg::result_t slot_b_reg;
    tbq_pkg::result_t slot_b_next;
    tbq_pkg::result_t res_first;
    tbq_pkg::result_t res_sent;
    logic [1:0]       rcnt_reg;
    logic [1:0]       rcnt_next;
    logic             out_take;

    // Accept while the result buffer is empty or its last result is taken this cycle
    assign out_take  = rsp.valid && rsp.ready;
    assign req.ready = (rcnt_reg == 2'd0) || ((rcnt_reg == 2'd1) && rsp.ready);
    assign fire      = req.valid && req.ready;
    assign is_enq    = (req.req_type == tbq_pkg::REQ_ENQUEUE);

    // Queue occupancy
    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign push     = fire && is_enq && !full;
    assign cnt_push = cnt_reg + CNT_W'(push);
    assign cnt_next = cnt_push - CNT_W'(pop);
    assign load_pos = pop ? (cnt_reg - 1'b1) : cnt_reg;
    assign head     = (cnt_reg == '0) ? req.line_handle : cell_data[0];

    // Pop only on an accepted item
    assign step.fire     = fire;
    assign step.is_tick  = fire && (req.req_type == tbq_pkg::REQ_TICK);
    assign step.has_line = fire && (cnt_push != '0);

    tbq_bucket u_bucket (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .pop       (pop)
    );

    // Cell chain: cell 0 is the head, pops shift every cell one place forward
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign cell_ctrl[i].shift = pop;
        assign cell_ctrl[i].load  = push && (load_pos == CNT_W'(i));

        if (i < DEPTH - 1)
        begin : g_mid
            tbq_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl[i]),
                .new_data  (req.line_handle),
                .next_data (cell_data[i+1]),
                .data      (cell_data[i])
            );
        end
        else
        begin : g_tail
            tbq_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl[i]),
                .new_data  (req.line_handle),
                .next_data (cell_data[i]),
                .data      (cell_data[i])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (fire)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Build the results of this item
    always_comb
    begin
        res_first.event_kind   = full ? tbq_pkg::EV_DROPPED : tbq_pkg::EV_ACCEPTED;
        res_first.sent_handle  = '0;
        res_first.fill_level   = tbq_pkg::FILL_W'(cnt_push);
        res_first.last_of_step = !pop;

        res_sent.event_kind    = tbq_pkg::EV_SENT;
        res_sent.sent_handle   = head;
        res_sent.fill_level    = tbq_pkg::FILL_W'(cnt_next);
        res_sent.last_of_step  = 1'b1;
    end

    // Result buffer: drain the front slot, load fresh results on accept
    always_comb
    begin
        slot_a_next = slot_a_reg;
        slot_b_next = slot_b_reg;
        rcnt_next   = rcnt_reg;
        if (out_take)
        begin
            slot_a_next = slot_b_reg;
            rcnt_next   = rcnt_reg - 1'b1;
        end
        if (fire)
        begin
            slot_a_next = is_enq ? res_first : res_sent;
            slot_b_next = res_sent;
            rcnt_next   = 2'(is_enq) + 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        slot_a_reg <= slot_a_next;
        slot_b_reg <= slot_b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcnt_reg <= 2'd0;
        end
        else
        begin
            rcnt_reg <= rcnt_next;
        end
    end

    assign rsp.valid        = (rcnt_reg != 2'd0);
    assign rsp.event_kind   = slot_a_reg.event_kind;
    assign rsp.sent_handle  = slot_a_reg.sent_handle;
    assign rsp.fill_level   = slot_a_reg.fill_level;
    assign rsp.last_of_step = slot_a_reg.last_of_step;

    a_rbuf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rcnt_reg <= 2'd2)
        else $error("result buffer overfilled");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("line queue count above depth");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && !rsp.last_of_step) |=> rsp.valid)
        else $error("second result of an item missing");

endmodule

`default_nettype wire
